// ===== design/dtsg_pkg.sv =====
// Package: shared constants, codes and command type for the dual-table stream generator.
`default_nettype none
package dtsg_pkg;

  localparam int unsigned TableDepth = 512;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned WordW      = 32;
  localparam int unsigned SeedW      = 64;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [WordW-1:0] FillMulP = 32'h9E3779B9;
  localparam logic [WordW-1:0] FillMulQ = 32'h85EBCA6B;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_SEED = 1'b0,
    CFG_MIX_SEED = 1'b1
  } dtsg_cfg_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_FILL = 3'd1,
    OP_RD_A = 3'd2,
    OP_RD_B = 3'd3,
    OP_RD_C = 3'd4,
    OP_UPD  = 3'd5,
    OP_OUT  = 3'd6
  } dtsg_op_e;

  typedef struct packed {
    dtsg_op_e             op;
    logic [IdxW-1:0]      idx;
    logic                 half;
    logic [IdxW-1:0]      fill_idx;
  } dtsg_cmd_t;

endpackage
`default_nettype wire

// ===== design/dtsg_if.sv =====
// Interfaces: input and output word channels with valid/ready handshake.
`default_nettype none
interface dtsg_in_if;
  logic valid;
  logic ready;
  logic reinit;

  modport source (output valid, output reinit, input ready);
  modport sink   (input valid, input reinit, output ready);
endinterface

interface dtsg_out_if;
  logic                          valid;
  logic                          ready;
  logic [dtsg_pkg::WordW-1:0]    rand_word;
  logic [dtsg_pkg::WordW-1:0]    p_entry;

  modport source (output valid, output rand_word, output p_entry, input ready);
  modport sink   (input valid, input rand_word, input p_entry, output ready);
endinterface
`default_nettype wire

// ===== design/dtsg_ctrl.sv =====
// Controller: step counter, table fill sweep and per-word sequencing.
`default_nettype none
module dtsg_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_reinit_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dtsg_pkg::dtsg_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_UPD,
    ST_OUT
  } state_e;

  state_e                        state_q;
  logic [31:0]                   count_q;
  logic [31:0]                   count_inc;
  logic [31:0]                   n_cur;
  logic [dtsg_pkg::IdxW-1:0]     fill_k_q;
  logic                          out_valid_q;
  logic                          accept;
  logic                          need_fill;
  logic                          load;
  logic                          out_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign need_fill   = in_reinit_i || (count_q == 32'd0);
  assign load        = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == ST_OUT) && load;
  assign n_cur       = count_q - 32'd1;
  assign count_inc   = count_q + 32'd1;

  always_comb begin
    cmd_o.op       = dtsg_pkg::OP_NONE;
    cmd_o.idx      = n_cur[dtsg_pkg::IdxW-1:0];
    cmd_o.half     = n_cur[dtsg_pkg::IdxW];
    cmd_o.fill_idx = fill_k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !need_fill) begin
          cmd_o.op = dtsg_pkg::OP_RD_A;
        end
      end
      ST_FILL: cmd_o.op = dtsg_pkg::OP_FILL;
      ST_RDA:  cmd_o.op = dtsg_pkg::OP_RD_A;
      ST_RDB:  cmd_o.op = dtsg_pkg::OP_RD_B;
      ST_RDC:  cmd_o.op = dtsg_pkg::OP_RD_C;
      ST_UPD:  cmd_o.op = dtsg_pkg::OP_UPD;
      ST_OUT: begin
        if (load) begin
          cmd_o.op = dtsg_pkg::OP_OUT;
        end
      end
      default: cmd_o.op = dtsg_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      fill_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            fill_k_q <= '0;
            state_q  <= need_fill ? ST_FILL : ST_RDB;
          end
        end
        ST_FILL: begin
          fill_k_q <= fill_k_q + 1'b1;
          if (fill_k_q == '1) begin
            count_q <= 32'd1;
            state_q <= ST_RDA;
          end
        end
        ST_RDA: state_q <= ST_RDB;
        ST_RDB: state_q <= ST_RDC;
        ST_RDC: state_q <= ST_UPD;
        ST_UPD: state_q <= ST_OUT;
        ST_OUT: begin
          if (load) begin
            count_q     <= (count_inc == 32'd0) ? 32'd1 : count_inc;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted word did not start work");

  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && fill_k_q == '1) |=> (state_q == ST_RDA && count_q == 32'd1))
    else $error("fill sweep did not hand over to the step");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && load) |=> out_valid_q)
    else $error("result not presented after load");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && load) |=> count_q != 32'd0)
    else $error("step counter wrapped to zero");

endmodule
`default_nettype wire

// ===== design/dtsg_datapath.sv =====
// Datapath: seed registers, P and Q tables, tap update and result register.
`default_nettype none
module dtsg_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dtsg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [dtsg_pkg::SeedW-1:0]        cfg_wdata_i,
  input  wire dtsg_pkg::dtsg_cmd_t               cmd_i,
  output logic [dtsg_pkg::WordW-1:0]             rand_word_o,
  output logic [dtsg_pkg::WordW-1:0]             p_entry_o
);

  localparam int unsigned IW = dtsg_pkg::IdxW;
  localparam int unsigned WW = dtsg_pkg::WordW;

  localparam logic [IW-1:0] Tap3  = IW'(3);
  localparam logic [IW-1:0] Tap10 = IW'(10);
  localparam logic [IW-1:0] Tap1  = IW'(1);
  localparam logic [IW-1:0] Tap12 = IW'(12);

  logic [dtsg_pkg::SeedW-1:0] key_q, mix_q;

  logic [WW-1:0] p_mem [dtsg_pkg::TableDepth];
  logic [WW-1:0] q_mem [dtsg_pkg::TableDepth];
  logic [WW-1:0] p_ra_q, p_rb_q, q_ra_q, q_rb_q;

  logic [IW-1:0] own_a, own_b, crs_a, crs_b;
  logic [IW-1:0] p_addr_a, p_addr_b, q_addr_a, q_addr_b;
  logic [WW-1:0] own_ra, own_rb, crs_ra, crs_rb;
  logic [IW-1:0] sel;
  logic [WW-1:0] new_word;
  logic [WW-1:0] x_q, sum_q, new_q;
  logic [WW-1:0] prod_p_q, prod_q_q, prod_p_cur, prod_q_cur;
  logic [WW-1:0] fill_p, fill_q;
  logic          re;
  logic          p_we, q_we;
  logic [IW-1:0] waddr;
  logic [WW-1:0] p_wdata, q_wdata;
  logic [WW-1:0] rand_q, pent_q;
  logic          half;

  assign half = cmd_i.half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      mix_q <= '0;
    end else if (cfg_we_i) begin
      case (dtsg_pkg::dtsg_cfg_e'(cfg_idx_i))
        dtsg_pkg::CFG_KEY_SEED: key_q <= cfg_wdata_i;
        dtsg_pkg::CFG_MIX_SEED: mix_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // read data of the own and cross tables
  assign own_ra = half ? q_ra_q : p_ra_q;
  assign own_rb = half ? q_rb_q : p_rb_q;
  assign crs_ra = half ? p_ra_q : q_ra_q;
  assign crs_rb = half ? p_rb_q : q_rb_q;

  // cross index from tap i-12: low byte plus top byte, at most 510
  assign sel      = {1'b0, own_rb[7:0]} + {1'b0, own_rb[WW-1:WW-8]};
  assign new_word = own_ra + sum_q;

  always_comb begin
    own_a = cmd_i.idx;
    own_b = cmd_i.idx;
    case (cmd_i.op)
      dtsg_pkg::OP_RD_A: begin
        own_a = cmd_i.idx - Tap3;
        own_b = cmd_i.idx - Tap10;
      end
      dtsg_pkg::OP_RD_B: begin
        own_a = cmd_i.idx + Tap1;
        own_b = cmd_i.idx - Tap1;
      end
      dtsg_pkg::OP_RD_C: begin
        own_a = cmd_i.idx;
        own_b = cmd_i.idx - Tap12;
      end
      default: ;
    endcase
  end

  assign crs_a    = sel;
  assign crs_b    = cmd_i.idx;
  assign p_addr_a = half ? crs_a : own_a;
  assign p_addr_b = half ? crs_b : own_b;
  assign q_addr_a = half ? own_a : crs_a;
  assign q_addr_b = half ? own_b : crs_b;

  assign re = (cmd_i.op == dtsg_pkg::OP_RD_A) || (cmd_i.op == dtsg_pkg::OP_RD_B) ||
              (cmd_i.op == dtsg_pkg::OP_RD_C) || (cmd_i.op == dtsg_pkg::OP_UPD);

  // fill: k * const kept as a running sum
  assign prod_p_cur = (cmd_i.fill_idx == '0) ? '0 : prod_p_q;
  assign prod_q_cur = (cmd_i.fill_idx == '0) ? '0 : prod_q_q;
  assign fill_p     = key_q[WW-1:0] ^ prod_p_cur ^ mix_q[2*WW-1:WW];
  assign fill_q     = key_q[2*WW-1:WW] ^ prod_q_cur ^ mix_q[WW-1:0];

  always_comb begin
    p_we    = 1'b0;
    q_we    = 1'b0;
    waddr   = cmd_i.idx;
    p_wdata = new_word;
    q_wdata = new_word;
    case (cmd_i.op)
      dtsg_pkg::OP_FILL: begin
        p_we    = 1'b1;
        q_we    = 1'b1;
        waddr   = cmd_i.fill_idx;
        p_wdata = fill_p;
        q_wdata = fill_q;
      end
      dtsg_pkg::OP_UPD: begin
        p_we = !half;
        q_we = half;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_mem[waddr] <= p_wdata;
    end
    if (re) begin
      p_ra_q <= p_mem[p_addr_a];
      p_rb_q <= p_mem[p_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[waddr] <= q_wdata;
    end
    if (re) begin
      q_ra_q <= q_mem[q_addr_a];
      q_rb_q <= q_mem[q_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      dtsg_pkg::OP_FILL: begin
        prod_p_q <= prod_p_cur + dtsg_pkg::FillMulP;
        prod_q_q <= prod_q_cur + dtsg_pkg::FillMulQ;
      end
      dtsg_pkg::OP_RD_B: x_q   <= own_ra ^ own_rb;
      dtsg_pkg::OP_RD_C: sum_q <= x_q + (own_ra ^ own_rb);
      dtsg_pkg::OP_UPD:  new_q <= new_word;
      dtsg_pkg::OP_OUT: begin
        rand_q <= crs_ra ^ new_q;
        pent_q <= half ? crs_rb : new_q;
      end
      default: ;
    endcase
  end

  assign rand_word_o = rand_q;
  assign p_entry_o   = pent_q;

endmodule
`default_nettype wire

// ===== design/dual_table_stream_generator.sv =====
// Top level: dual-table stream generator, controller plus datapath.
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid/ready   | reinit (1)
//  out_o   | out | valid/ready   | rand_word (32), p_entry (32)
//  cfg     | in  | cfg_we_i only | cfg_idx_i (1), cfg_wdata_i (64)
//
// A word takes three tap read steps and the update step on the two-read-port
// P/Q memories, then the result load; the next word is accepted only once the
// result load has returned the controller to idle.
// Reset, reinit or a zero step count adds a fill sweep over all 512 entries,
// one entry of P and Q per cycle, plus the first tap read; ready stays low.
// The result register holds a word until taken; the next word is accepted
// meanwhile and waits in its last step only if the register is still full.
`default_nettype none
module dual_table_stream_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dtsg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dtsg_pkg::SeedW-1:0]    cfg_wdata_i,
  dtsg_in_if.sink                            in_i,
  dtsg_out_if.source                         out_o
);

  dtsg_pkg::dtsg_cmd_t cmd;

  dtsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_reinit_i (in_i.reinit),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  dtsg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .rand_word_o (out_o.rand_word),
    .p_entry_o   (out_o.p_entry)
  );

endmodule
`default_nettype wire

// ===== test/tb_dual_table_stream_generator.sv =====
// Testbench: directed table then random bursts, every word checked against a table model or a pinned value.
`timescale 1ns / 100ps
module tb_dual_table_stream_generator;

  localparam int unsigned HoldCycles  = 3000;
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned PhaseWords  = 345;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned DirRows     = 26;

  typedef struct packed {
    logic [dtsg_pkg::WordW-1:0] rand_word;
    logic [dtsg_pkg::WordW-1:0] p_entry;
  } word_t;

  typedef struct packed {
    logic                       seeds;
    logic                       reinit;
    logic                       pin;
    logic [dtsg_pkg::WordW-1:0] rand_word;
    logic [dtsg_pkg::WordW-1:0] p_entry;
    logic [dtsg_pkg::SeedW-1:0] key;
    logic [dtsg_pkg::SeedW-1:0] mix;
  } dir_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [dtsg_pkg::CfgIdxW-1:0] cfg_idx;
  logic [dtsg_pkg::SeedW-1:0]   cfg_wdata;

  logic                         pin_en;
  logic [dtsg_pkg::WordW-1:0]   pin_word;
  logic [dtsg_pkg::WordW-1:0]   pin_p;
  logic                         hold_req;
  int                           errs;

  logic [dtsg_pkg::WordW-1:0]   gen_tbl [2][dtsg_pkg::TableDepth];
  logic [dtsg_pkg::WordW-1:0]   gen_step;
  logic [dtsg_pkg::SeedW-1:0]   key_reg;
  logic [dtsg_pkg::SeedW-1:0]   mix_reg;
  word_t                        words_due [$];

  // first word after a fill where P[k] = k*FillMulP and Q[k] = k*FillMulQ
  dir_row_t dir_rows [DirRows] = '{
    '{1'b0, 1'b0, 1'b1, 32'h2A1FA2D9, 32'h23123611, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b1, 1'b1, 32'h2A1FA2D9, 32'h23123611, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 64'hFFFFFFFF_00000000, 64'h00000000_FFFFFFFF},
    '{1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 64'h00000000_FFFFFFFF, 64'hFFFFFFFF_00000000},
    '{1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 64'h01234567_89ABCDEF, 64'hFEDCBA98_76543210},
    '{1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 64'h0, 64'h0}
  };

  dtsg_in_if  in_if ();
  dtsg_out_if out_if ();

  dual_table_stream_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [dtsg_pkg::IdxW-1:0] wrap(input int v);
    return v[dtsg_pkg::IdxW-1:0];
  endfunction

  function automatic word_t gen_word(input logic reinit);
    logic [dtsg_pkg::WordW-1:0] n;
    logic [dtsg_pkg::WordW-1:0] kv;
    logic [dtsg_pkg::WordW-1:0] t12;
    logic [dtsg_pkg::IdxW-1:0]  i;
    logic [dtsg_pkg::IdxW-1:0]  sel;
    logic                       h;
    word_t                      res;
    if (reinit) gen_step = '0;
    if (gen_step == '0) begin
      for (kv = 0; kv < dtsg_pkg::TableDepth; kv++) begin
        gen_tbl[0][kv[dtsg_pkg::IdxW-1:0]] =
          key_reg[31:0] ^ (kv * dtsg_pkg::FillMulP) ^ mix_reg[63:32];
        gen_tbl[1][kv[dtsg_pkg::IdxW-1:0]] =
          key_reg[63:32] ^ (kv * dtsg_pkg::FillMulQ) ^ mix_reg[31:0];
      end
      gen_step = 1;
    end
    n = gen_step - 1;
    i = n[dtsg_pkg::IdxW-1:0];
    h = n[dtsg_pkg::IdxW];
    gen_tbl[h][i] = gen_tbl[h][i] +
                    ((gen_tbl[h][wrap(i - 3)] ^ gen_tbl[h][wrap(i - 10)]) +
                     (gen_tbl[h][wrap(i + 1)] ^ gen_tbl[h][wrap(i - 1)]));
    t12 = gen_tbl[h][wrap(i - 12)];
    sel = {1'b0, t12[7:0]} + {1'b0, t12[31:24]};
    res.rand_word = gen_tbl[!h][sel] ^ gen_tbl[h][i];
    res.p_entry   = gen_tbl[0][i];
    gen_step = gen_step + 1;
    if (gen_step == '0) gen_step = 1;
    return res;
  endfunction

  task automatic send_word(input logic r, input logic pin,
                           input logic [dtsg_pkg::WordW-1:0] w,
                           input logic [dtsg_pkg::WordW-1:0] p);
    in_if.valid  <= 1'b1;
    in_if.reinit <= r;
    pin_en       <= pin;
    pin_word     <= w;
    pin_p        <= p;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_seeds(input logic [dtsg_pkg::SeedW-1:0] k,
                           input logic [dtsg_pkg::SeedW-1:0] m);
    cfg_we    <= 1'b1;
    cfg_idx   <= dtsg_pkg::CFG_KEY_SEED;
    cfg_wdata <= k;
    @(posedge clk_i);
    cfg_idx   <= dtsg_pkg::CFG_MIX_SEED;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    key_reg = k;
    mix_reg = m;
  endtask

  always @(posedge clk_i) begin : in_mon
    word_t due;
    if (in_if.valid && in_if.ready) begin
      due = gen_word(in_if.reinit);
      if (pin_en) due = '{pin_word, pin_p};
      words_due.push_back(due);
    end
  end

  always @(posedge clk_i) begin : out_mon
    word_t due;
    if (out_if.valid && out_if.ready) begin
      if (words_due.size() == 0) begin
        errs++;
        $error("unexpected word: rand_word %h p_entry %h", out_if.rand_word, out_if.p_entry);
      end else begin
        due = words_due.pop_front();
        if (out_if.rand_word !== due.rand_word) begin
          errs++;
          $error("rand_word: expected %h, got %h", due.rand_word, out_if.rand_word);
        end
        if (out_if.p_entry !== due.p_entry) begin
          errs++;
          $error("p_entry: expected %h, got %h", due.p_entry, out_if.p_entry);
        end
      end
    end
  end

  // receiver: segments of random stall patterns, one long hold on request
  initial begin : rx_side
    int seg_left;
    int rx_mode;
    int tick;
    seg_left = 0;
    rx_mode  = 0;
    tick     = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        rx_mode  = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      tick++;
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (tick % 3 == 0);
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("dual_table_stream_generator regression: fail");
    $finish;
  end

  initial begin : stim
    int          n;
    int          ph;
    logic        rn;
    logic [63:0] k;
    logic [63:0] m;
    errs     = 0;
    hold_req = 1'b0;
    gen_step = '0;
    key_reg  = '0;
    mix_reg  = '0;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= dtsg_pkg::CFG_KEY_SEED;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.reinit <= 1'b0;
    pin_en       <= 1'b0;
    pin_word     <= '0;
    pin_p        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      if (dir_rows[r].seeds) begin
        drain();
        set_seeds(dir_rows[r].key, dir_rows[r].mix);
      end else begin
        send_word(dir_rows[r].reinit, dir_rows[r].pin, dir_rows[r].rand_word,
                  dir_rows[r].p_entry);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        1: begin
          k = '0;
          m = '1;
        end
        2: begin
          k = '1;
          m = '0;
        end
        default: begin
          k = {$urandom, $urandom};
          m = {$urandom, $urandom};
        end
      endcase
      set_seeds(k, m);
      if (ph == 1) hold_req = 1'b1;
      n = 0;
      while (n < PhaseWords) begin
        repeat ($urandom_range(1, 24)) begin
          // odd phases refill from the new seeds, even ones keep the old tables unless a rare random reinit comes
          rn = ($urandom_range(0, 399) == 0) || (n == 0 && ph[0]);
          send_word(rn, 1'b0, '0, '0);
          n++;
        end
        if ($urandom_range(0, 3) != 0) begin
          in_if.valid  <= 1'b0;
          in_if.reinit <= 1'($urandom_range(0, 1));
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (errs == 0 && words_due.size() == 0) begin
      $display("dual_table_stream_generator regression: pass");
    end else begin
      $display("dual_table_stream_generator regression: fail");
    end
    $finish;
  end

endmodule

// ===== dual_table_stream_generator.f =====
design/dtsg_pkg.sv
design/dtsg_if.sv
design/dtsg_ctrl.sv
design/dtsg_datapath.sv
design/dual_table_stream_generator.sv
test/tb_dual_table_stream_generator.sv
